// File: sv/percent_decoder_stream_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the percent decoder stream
// Clocked checks, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERCENT_DECODER_STREAM_ASSERT_SVH
`define PERCENT_DECODER_STREAM_ASSERT_SVH

// property holds at every clock edge out of reset
`define PDEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition never holds at a clock edge out of reset
`define PDEC_NEVER(lbl, cond, msg) \
	`PDEC_ASSERT(lbl, !(cond), msg)

`endif

// File: sv/pdec_pkg.sv
// ----------------------------------------------------------------------------
// Percent decoder package
// Item types, escape phase, character codes and hex helpers.
// ----------------------------------------------------------------------------
package pdec_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [3:0] HEX_TEN    = 4'd10;
	localparam int unsigned JOB_MAX   = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [JOB_MAX-1:0][7:0] job_bytes;
		logic [1:0]              count;
		logic                    last;
	} job_t;

	typedef enum logic [1:0] {
		ESC_IDLE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		if (c <= 8'h39) begin
			hex_val = c[3:0];
		end else begin
			hex_val = 4'(c[3:0] + HEX_TEN - 4'd1);
		end
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] c);
		plain_byte = (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

// File: sv/pdec_front.sv
// ----------------------------------------------------------------------------
// Percent decoder front end
// Accepts raw bytes, tracks the escape phase and pushes at most one job per byte.
// ----------------------------------------------------------------------------
module pdec_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pdec_pkg::in_item_t in_item,
	input  logic              full,
	output logic              push,
	output pdec_pkg::job_t    job
);

	pdec_pkg::esc_phase_t phase_q;
	pdec_pkg::esc_phase_t phase_d;
	logic [7:0]           held_q;
	logic                 accept;
	logic                 b_hex;
	logic                 b_pct;
	logic [7:0]           b;

	assign b      = in_item.in_byte;
	assign b_hex  = pdec_pkg::is_hex(b);
	assign b_pct  = (b == pdec_pkg::CH_PERCENT);
	assign in_stall = full;
	assign accept = in_valid && !full;
	assign push   = accept && (job.count != 2'd0);

	always_comb begin
		phase_d = pdec_pkg::ESC_IDLE;
		case (phase_q)
			pdec_pkg::ESC_PCT: begin
				if (b_hex) begin
					phase_d = pdec_pkg::ESC_DIGIT;
				end else if (b_pct) begin
					phase_d = pdec_pkg::ESC_PCT;
				end
			end
			pdec_pkg::ESC_DIGIT: begin
				if (!b_hex && b_pct) begin
					phase_d = pdec_pkg::ESC_PCT;
				end
			end
			default: begin
				if (b_pct) begin
					phase_d = pdec_pkg::ESC_PCT;
				end
			end
		endcase
		if (in_item.in_last) begin
			phase_d = pdec_pkg::ESC_IDLE;
		end
	end

	always_comb begin
		job       = '0;
		job.last  = in_item.in_last;
		case (phase_q)
			pdec_pkg::ESC_PCT: begin
				if (b_hex) begin
					if (in_item.in_last) begin
						job.job_bytes[0] = pdec_pkg::CH_PERCENT;
						job.job_bytes[1] = b;
						job.count        = 2'd2;
					end
				end else begin
					job.job_bytes[0] = pdec_pkg::CH_PERCENT;
					if (!b_pct) begin
						job.job_bytes[1] = pdec_pkg::plain_byte(b);
						job.count        = 2'd2;
					end else if (in_item.in_last) begin
						job.job_bytes[1] = pdec_pkg::CH_PERCENT;
						job.count        = 2'd2;
					end else begin
						job.count        = 2'd1;
					end
				end
			end
			pdec_pkg::ESC_DIGIT: begin
				if (b_hex) begin
					job.job_bytes[0] = {pdec_pkg::hex_val(held_q), pdec_pkg::hex_val(b)};
					job.count        = 2'd1;
				end else begin
					job.job_bytes[0] = pdec_pkg::CH_PERCENT;
					job.job_bytes[1] = held_q;
					if (!b_pct) begin
						job.job_bytes[2] = pdec_pkg::plain_byte(b);
						job.count        = 2'd3;
					end else if (in_item.in_last) begin
						job.job_bytes[2] = pdec_pkg::CH_PERCENT;
						job.count        = 2'd3;
					end else begin
						job.count        = 2'd2;
					end
				end
			end
			default: begin
				if (!b_pct) begin
					job.job_bytes[0] = pdec_pkg::plain_byte(b);
					job.count        = 2'd1;
				end else if (in_item.in_last) begin
					job.job_bytes[0] = pdec_pkg::CH_PERCENT;
					job.count        = 2'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pdec_pkg::ESC_IDLE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == pdec_pkg::ESC_PCT && b_hex) begin
			held_q <= b;
		end
	end

endmodule

// File: sv/pdec_fifo.sv
// ----------------------------------------------------------------------------
// Percent decoder job queue
// Two-entry queue of output jobs between front end and back end.
// ----------------------------------------------------------------------------
`include "percent_decoder_stream_assert.svh"

module pdec_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pdec_pkg::job_t wr_job,
	input  logic           pop,
	output pdec_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);

	pdec_pkg::job_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	`PDEC_NEVER(a_push_full, push && full, "job pushed into a full queue")
	`PDEC_NEVER(a_pop_empty, pop && empty, "job popped from an empty queue")
	`PDEC_ASSERT(a_head_nonempty, !empty |-> rd_job.count != 2'd0, "queued job carries no bytes")

endmodule

// File: sv/pdec_back.sv
// ----------------------------------------------------------------------------
// Percent decoder back end
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module pdec_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pdec_pkg::job_t     head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output pdec_pkg::out_item_t out_item
);

	logic [1:0]          idx_q;
	logic                out_valid_q;
	pdec_pkg::out_item_t out_q;
	logic                load;
	logic                final_byte;

	assign load       = !empty && (!out_valid_q || !out_stall);
	assign final_byte = (idx_q == 2'(head.count - 2'd1));
	assign pop        = load && final_byte;
	assign out_valid  = out_valid_q;
	assign out_item   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= !empty;
			end
			if (load) begin
				idx_q <= final_byte ? 2'd0 : 2'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head.job_bytes[idx_q];
			out_q.out_last <= head.last && final_byte;
		end
	end

endmodule

// File: sv/percent_decoder_stream.sv
// ----------------------------------------------------------------------------
// Percent decoder stream
// URL form decoding of a flagged byte stream.
// ----------------------------------------------------------------------------
// One encoded byte is taken per clock cycle while the job queue is not full.
// Each byte yields zero to three decoded bytes; the output side hands out one
// decoded byte per cycle unless stalled, so a byte giving k results holds the
// back end until all k are out; the rate is set by that single output register.
// A two-entry job queue holds up to two bytes' jobs while the output stalls;
// the input stalls while it is full. A first result is queued, then registered.
module percent_decoder_stream (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  pdec_pkg::in_item_t  src_item,
	output logic               dst_valid,
	input  logic               dst_stall,
	output pdec_pkg::out_item_t dst_item
);

	pdec_pkg::job_t wr_job;
	pdec_pkg::job_t head;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	pdec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (src_valid),
		.in_stall (src_stall),
		.in_item  (src_item),
		.full     (full),
		.push     (push),
		.job      (wr_job)
	);

	pdec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (head),
		.full   (full),
		.empty  (empty)
	);

	pdec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (dst_valid),
		.out_stall (dst_stall),
		.out_item  (dst_item)
	);

endmodule
